// File: rtl/rmfb_pkg.sv
// Shared types, codes and constants of the rotated monochrome frame store engine.
`default_nettype none

package rmfb_pkg;

   // Default panel geometry (physical pixels)
   localparam int DEF_PANEL_WIDTH  = 128;
   localparam int DEF_PANEL_HEIGHT = 64;

   // Request field widths
   localparam int OP_W    = 3;
   localparam int COORD_IN_W = 16;
   localparam int RUN_W   = 12;
   localparam int ROT_W   = 2;

   // Rotation register codes, clockwise
   localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
   localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
   localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
   localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

   // Internal coordinate widths, sized for panels of up to 256 pixels a side
   localparam int COORD_W = 8;
   localparam int CNT_W   = COORD_W + 1;

   // Page organization: 8 rows per byte
   localparam int PAGE_ROWS  = 8;
   localparam int PAGE_SHIFT = 3;
   localparam int BYTE_W     = 8;
   localparam logic [BYTE_W-1:0] FILL_LIT = 8'hFF;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [OP_W-1:0] {
      OP_SET  = 3'd0,
      OP_READ = 3'd1,
      OP_HRUN = 3'd2,
      OP_VRUN = 3'd3,
      OP_FILL = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_DRAW = 2'd1,
      KIND_READ = 2'd2,
      KIND_FILL = 2'd3
   } cmd_kind_type;

   // Classified command: a clipped span along one logical axis
   typedef struct packed {
      cmd_kind_type       kind;
      logic               vertical;
      logic [COORD_W-1:0] along;
      logic [COORD_W-1:0] fixed;
      logic [CNT_W-1:0]   count;
      logic               ink;
   } cmd_type;

endpackage

`default_nettype wire

// File: rtl/rmfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rmfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/rmfb_front.sv
// Front end: request register, bounds check and span clipping into a command.
`default_nettype none

module rmfb_front #(
   parameter int PANEL_WIDTH  = rmfb_pkg::DEF_PANEL_WIDTH,
   parameter int PANEL_HEIGHT = rmfb_pkg::DEF_PANEL_HEIGHT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept_en,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [rmfb_pkg::OP_W-1:0]             req_op,
   input  logic signed [rmfb_pkg::COORD_IN_W-1:0] req_x_coord,
   input  logic signed [rmfb_pkg::COORD_IN_W-1:0] req_y_coord,
   input  logic [rmfb_pkg::RUN_W-1:0]            req_run_length,
   input  logic                                  req_ink,
   input  logic [rmfb_pkg::ROT_W-1:0]            rotation,
   output logic                                  push_valid,
   input  logic                                  push_ready,
   output rmfb_pkg::cmd_type                     push_cmd
);

   localparam int SPAN_W = rmfb_pkg::COORD_IN_W + 2;
   localparam logic signed [SPAN_W-1:0] WIDTH_S  = SPAN_W'(PANEL_WIDTH);
   localparam logic signed [SPAN_W-1:0] HEIGHT_S = SPAN_W'(PANEL_HEIGHT);

   logic                                   valid_ff, valid_in;
   logic [rmfb_pkg::OP_W-1:0]              op_ff;
   logic signed [rmfb_pkg::COORD_IN_W-1:0] x_ff, y_ff;
   logic [rmfb_pkg::RUN_W-1:0]             len_ff;
   logic                                   ink_ff;

   logic accept, push;
   logic vertical, is_run, fixed_ok;
   logic signed [SPAN_W-1:0] lw_s, lh_s, along_s, fixed_s, len_s;
   logic signed [SPAN_W-1:0] along_lim_s, fixed_lim_s, lo_s, end_s, hi_s, span_s;

   assign push      = valid_ff && push_ready;
   assign req_ready = accept_en && (!valid_ff || push_ready);
   assign accept    = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_op;
         x_ff   <= req_x_coord;
         y_ff   <= req_y_coord;
         len_ff <= req_run_length;
         ink_ff <= req_ink;
      end
   end

   // Clip the span [start, start+len) against the logical extent of its axis
   always_comb begin
      vertical    = (op_ff == rmfb_pkg::OP_VRUN);
      is_run      = (op_ff == rmfb_pkg::OP_HRUN) || vertical;
      lw_s        = rotation[0] ? HEIGHT_S : WIDTH_S;
      lh_s        = rotation[0] ? WIDTH_S : HEIGHT_S;
      along_s     = vertical ? SPAN_W'(y_ff) : SPAN_W'(x_ff);
      fixed_s     = vertical ? SPAN_W'(x_ff) : SPAN_W'(y_ff);
      along_lim_s = vertical ? lh_s : lw_s;
      fixed_lim_s = vertical ? lw_s : lh_s;
      len_s       = is_run ? signed'(SPAN_W'(len_ff)) : SPAN_W'(1);
      fixed_ok    = !fixed_s[SPAN_W-1] && (fixed_s < fixed_lim_s);
      lo_s        = along_s[SPAN_W-1] ? '0 : along_s;
      end_s       = along_s + len_s;
      hi_s        = (end_s > along_lim_s) ? along_lim_s : end_s;
      span_s      = hi_s - lo_s;

      push_cmd.vertical = vertical;
      push_cmd.along    = lo_s[rmfb_pkg::COORD_W-1:0];
      push_cmd.fixed    = fixed_s[rmfb_pkg::COORD_W-1:0];
      push_cmd.count    = (fixed_ok && (hi_s > lo_s)) ? span_s[rmfb_pkg::CNT_W-1:0] : '0;
      push_cmd.ink      = ink_ff;
      case (op_ff)
         rmfb_pkg::OP_SET,
         rmfb_pkg::OP_HRUN,
         rmfb_pkg::OP_VRUN: push_cmd.kind = rmfb_pkg::KIND_DRAW;
         rmfb_pkg::OP_READ: push_cmd.kind = rmfb_pkg::KIND_READ;
         rmfb_pkg::OP_FILL: push_cmd.kind = rmfb_pkg::KIND_FILL;
         default:           push_cmd.kind = rmfb_pkg::KIND_NONE;
      endcase
   end

   assign push_valid = valid_ff;

endmodule

`default_nettype wire

// File: rtl/rmfb_queue.sv
// Short command queue decoupling the front end from the store sequencer.
`default_nettype none

module rmfb_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  rmfb_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop,
   output rmfb_pkg::cmd_type pop_cmd
);

   localparam int DEPTH = rmfb_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rmfb_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_cmd    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// File: rtl/rmfb_back.sv
// Back end: store sequencer doing rotation mapping, read-modify-write, fill and clear.
`default_nettype none

module rmfb_back #(
   parameter int PANEL_WIDTH  = rmfb_pkg::DEF_PANEL_WIDTH,
   parameter int PANEL_HEIGHT = rmfb_pkg::DEF_PANEL_HEIGHT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [rmfb_pkg::ROT_W-1:0] rotation,
   input  logic                       pop_valid,
   input  rmfb_pkg::cmd_type          pop_cmd,
   output logic                       pop,
   output logic                       clear_busy,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_pixel_value
);

   localparam int PAGE_COUNT  = (PANEL_HEIGHT + rmfb_pkg::PAGE_ROWS - 1) / rmfb_pkg::PAGE_ROWS;
   localparam int STORE_BYTES = PANEL_WIDTH * PAGE_COUNT;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int CALC_W      = ADDR_W + 1;
   localparam int MAP_W       = rmfb_pkg::COORD_W + 1;
   localparam int BYTE_W      = rmfb_pkg::BYTE_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);
   localparam logic [MAP_W-1:0]  WIDTH_M1  = MAP_W'(PANEL_WIDTH - 1);
   localparam logic [MAP_W-1:0]  HEIGHT_M1 = MAP_W'(PANEL_HEIGHT - 1);

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_ADDR  = 6'b000100,
      ST_MOD   = 6'b001000,
      ST_FILL  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type                   state_ff, state_in;
   logic [ADDR_W-1:0]           sweep_ff, sweep_in;
   rmfb_pkg::cmd_kind_type      kind_ff, kind_in;
   logic                        vertical_ff, vertical_in;
   logic [rmfb_pkg::COORD_W-1:0] along_ff, along_in, fixed_ff, fixed_in;
   logic [rmfb_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                        ink_ff, ink_in;
   logic [ADDR_W-1:0]           waddr_ff, waddr_in;
   logic [rmfb_pkg::PAGE_SHIFT-1:0] bit_ff, bit_in;
   logic                        result_ff, result_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_value_ff, rsp_value_in;

   logic               out_free, done_go, done_value;
   logic [MAP_W-1:0]   lx, ly, px, py, page;
   logic [CALC_W-1:0]  addr_wide;
   logic [ADDR_W-1:0]  map_addr;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [BYTE_W-1:0]  wr_data, rd_data, pix_mask;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign clear_busy = (state_ff == ST_CLEAR);

   // Rotate logical (x, y) to a physical byte address and bit in its page
   always_comb begin
      lx = vertical_ff ? MAP_W'(fixed_ff) : MAP_W'(along_ff);
      ly = vertical_ff ? MAP_W'(along_ff) : MAP_W'(fixed_ff);
      case (rotation)
         rmfb_pkg::ROT_90: begin
            px = WIDTH_M1 - ly;
            py = lx;
         end
         rmfb_pkg::ROT_180: begin
            px = WIDTH_M1 - lx;
            py = HEIGHT_M1 - ly;
         end
         rmfb_pkg::ROT_270: begin
            px = ly;
            py = HEIGHT_M1 - lx;
         end
         default: begin
            px = lx;
            py = ly;
         end
      endcase
      page      = py >> rmfb_pkg::PAGE_SHIFT;
      addr_wide = CALC_W'(page) * CALC_W'(PANEL_WIDTH) + CALC_W'(px);
      map_addr  = addr_wide[ADDR_W-1:0];
   end

   assign pix_mask = BYTE_W'(1) << bit_ff;

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      kind_in      = kind_ff;
      vertical_in  = vertical_ff;
      along_in     = along_ff;
      fixed_in     = fixed_ff;
      count_in     = count_ff;
      ink_in       = ink_ff;
      waddr_in     = waddr_ff;
      bit_in       = bit_ff;
      result_in    = result_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = sweep_ff;
      wr_data      = '0;
      done_go      = 1'b0;
      done_value   = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            wr_en    = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST_ADDR) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (pop_valid) begin
               pop         = 1'b1;
               kind_in     = pop_cmd.kind;
               vertical_in = pop_cmd.vertical;
               along_in    = pop_cmd.along;
               fixed_in    = pop_cmd.fixed;
               count_in    = pop_cmd.count;
               ink_in      = pop_cmd.ink;
               case (pop_cmd.kind)
                  rmfb_pkg::KIND_FILL: begin
                     sweep_in = '0;
                     state_in = ST_FILL;
                  end
                  rmfb_pkg::KIND_DRAW,
                  rmfb_pkg::KIND_READ: begin
                     if (pop_cmd.count != '0) begin
                        state_in = ST_ADDR;
                     end else begin
                        done_go = 1'b1;
                     end
                  end
                  default: done_go = 1'b1;
               endcase
            end
         end
         ST_ADDR: begin
            waddr_in = map_addr;
            bit_in   = py[rmfb_pkg::PAGE_SHIFT-1:0];
            state_in = ST_MOD;
         end
         ST_MOD: begin
            if (kind_ff == rmfb_pkg::KIND_READ) begin
               done_go    = 1'b1;
               done_value = rd_data[bit_ff];
            end else begin
               wr_en    = 1'b1;
               wr_addr  = waddr_ff;
               wr_data  = ink_ff ? (rd_data | pix_mask) : (rd_data & ~pix_mask);
               along_in = along_ff + 1'b1;
               count_in = count_ff - 1'b1;
               if (count_ff == rmfb_pkg::CNT_W'(1)) begin
                  done_go = 1'b1;
               end else begin
                  state_in = ST_ADDR;
               end
            end
         end
         ST_FILL: begin
            wr_en    = 1'b1;
            wr_data  = ink_ff ? rmfb_pkg::FILL_LIT : '0;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST_ADDR) begin
               sweep_in = '0;
               done_go  = 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (done_go) begin
         result_in = done_value;
         state_in  = out_free ? ST_IDLE : ST_DONE;
      end
   end

   // Response register: load on completion, hold while stalled
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      if (done_go && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = done_value;
      end else if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = result_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      vertical_ff  <= vertical_in;
      along_ff     <= along_in;
      fixed_ff     <= fixed_in;
      count_ff     <= count_in;
      ink_ff       <= ink_in;
      waddr_ff     <= waddr_in;
      bit_ff       <= bit_in;
      result_ff    <= result_in;
      rsp_value_ff <= rsp_value_in;
   end

   rmfb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (map_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_value = rsp_value_ff;

endmodule

`default_nettype wire

// File: rtl/rotated_mono_framebuffer_pixel_engine_core.sv
// Top level of the rotated monochrome page-organized frame store pixel engine.
// An on-screen set or read pixel request passes the front register, the command queue and
//    the sequencer states ADDR and MOD before its response is registered. Each drawn pixel
//    of a run takes its own ADDR and MOD visit; a fill writes one store byte per cycle.
// Reset: synchronous; afterwards a clearing pass writes zeros to all
//    PANEL_WIDTH*ceil(PANEL_HEIGHT/8) bytes with req_ready low.
`default_nettype none

module rotated_mono_framebuffer_pixel_engine_core #(
   parameter int PANEL_WIDTH  = rmfb_pkg::DEF_PANEL_WIDTH,
   parameter int PANEL_HEIGHT = rmfb_pkg::DEF_PANEL_HEIGHT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [rmfb_pkg::OP_W-1:0]              req_op,
   input  logic signed [rmfb_pkg::COORD_IN_W-1:0] req_x_coord,
   input  logic signed [rmfb_pkg::COORD_IN_W-1:0] req_y_coord,
   input  logic [rmfb_pkg::RUN_W-1:0]             req_run_length,
   input  logic                                   req_ink,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_pixel_value,
   // rotation register write
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [rmfb_pkg::ROT_W-1:0]             csr_rotation
);

   logic [rmfb_pkg::ROT_W-1:0] rotation_ff, rotation_in;
   logic                       clear_busy;
   logic                       push_valid, push_ready, pop_valid, pop;
   rmfb_pkg::cmd_type          push_cmd, pop_cmd;

   // Rotation register: always writable; the host writes it only while no request
   // is in flight, since both front and back read it live
   assign csr_ready   = 1'b1;
   assign rotation_in = (csr_valid && csr_ready) ? csr_rotation : rotation_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_ff <= '0;
      end else begin
         rotation_ff <= rotation_in;
      end
   end

   // Front: register the request, bounds-check and clip it into one command.
   // Hold off new requests while the post-reset clearing pass runs.
   rmfb_front #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept_en      (!clear_busy),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_x_coord    (req_x_coord),
      .req_y_coord    (req_y_coord),
      .req_run_length (req_run_length),
      .req_ink        (req_ink),
      .rotation       (rotation_ff),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_cmd       (push_cmd)
   );

   // Queue: lets the front keep taking requests while the back works through a run
   rmfb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_cmd    (pop_cmd)
   );

   // Back: rotate each pixel to a store byte, read-modify-write it, sweep fills,
   // and drive the response register (one response per request, in order).
   rmfb_back #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .rotation        (rotation_ff),
      .pop_valid       (pop_valid),
      .pop_cmd         (pop_cmd),
      .pop             (pop),
      .clear_busy      (clear_busy),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_value (rsp_pixel_value)
   );

   // No request may enter while the store is being cleared
   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req_ready)
      else $error("request channel open during clearing pass");

   // Leaving reset always starts the clearing pass
   a_reset_starts_clear: assert property (@(posedge clock)
      $fell(reset) |-> clear_busy)
      else $error("clearing pass not started after reset");

   // No response can exist before the store has been cleared
   a_no_rsp_while_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !rsp_valid)
      else $error("response presented during clearing pass");

endmodule

`default_nettype wire

// File: verif/tb_rotated_mono_framebuffer_pixel_engine_core.sv
// Self-checking testbench for the rotated monochrome frame store pixel engine.
`default_nettype none

module tb_rotated_mono_framebuffer_pixel_engine_core;

   // Geometry of the store under test
   localparam int PANEL_W     = rmfb_pkg::DEF_PANEL_WIDTH;
   localparam int PANEL_H     = rmfb_pkg::DEF_PANEL_HEIGHT;
   localparam int PAGE_ROWS   = rmfb_pkg::PAGE_ROWS;
   localparam int PAGE_COUNT  = (PANEL_H + PAGE_ROWS - 1) / PAGE_ROWS;
   localparam int STORE_BYTES = PANEL_W * PAGE_COUNT;
   localparam int OP_W        = rmfb_pkg::OP_W;
   localparam int COORD_IN_W  = rmfb_pkg::COORD_IN_W;
   localparam int RUN_W       = rmfb_pkg::RUN_W;
   localparam int ROT_W       = rmfb_pkg::ROT_W;
   localparam int BYTE_W      = rmfb_pkg::BYTE_W;

   // Run shape
   localparam int DIRECTED_ROWS    = 27;
   localparam int PHASE_COUNT      = 8;
   localparam int RANDOM_PER_PHASE = 125;
   localparam int STALL_LIMIT      = 6000;  // cycles without any handshake
   localparam int DRAIN_CYCLES     = 20;

   // Op codes the block ignores
   localparam logic [OP_W-1:0] OP_SPARE5 = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

   // One drawing request; typed marks a row whose response is written into the table
   typedef struct packed {
      logic [OP_W-1:0]       op;
      logic [COORD_IN_W-1:0] x_coord;
      logic [COORD_IN_W-1:0] y_coord;
      logic [RUN_W-1:0]      run_length;
      logic                  ink;
      logic                  typed;
      logic                  typed_pixel;
   } pixel_request_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [OP_W-1:0]       req_op;
   logic signed [COORD_IN_W-1:0] req_x_coord;
   logic signed [COORD_IN_W-1:0] req_y_coord;
   logic [RUN_W-1:0]      req_run_length;
   logic                  req_ink;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_pixel_value;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [ROT_W-1:0]      csr_rotation;

   // Shadow copy of the frame store and the rotation register
   logic [BYTE_W-1:0]     frame_shadow [0:STORE_BYTES-1];
   logic [ROT_W-1:0]      shadow_rotation;

   // Pixel values still owed by the block, oldest first
   logic                  pending_pixels [$];
   int                    mismatch_count = 0;
   int                    stuck_cycles   = 0;
   int                    ready_hold     = 0;
   bit                    quiet_run      = 1'b0;

   pixel_request_type     directed_table [0:DIRECTED_ROWS-1];
   logic [ROT_W-1:0]      rotation_plan  [0:PHASE_COUNT-1];

   rotated_mono_framebuffer_pixel_engine_core #(
      .PANEL_WIDTH  (PANEL_W),
      .PANEL_HEIGHT (PANEL_H)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_x_coord     (req_x_coord),
      .req_y_coord     (req_y_coord),
      .req_run_length  (req_run_length),
      .req_ink         (req_ink),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_value (rsp_pixel_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_rotation    (csr_rotation)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Map a logical pixel to its store byte and bit; return 0 when it lies off the display.
   function automatic bit locate_pixel(input int x, input int y,
                                       output int byte_addr, output logic [BYTE_W-1:0] pix_mask);
      bit sideways;
      int lw, lh, px, py;
      sideways  = (shadow_rotation == rmfb_pkg::ROT_90) ||
                  (shadow_rotation == rmfb_pkg::ROT_270);
      lw        = sideways ? PANEL_H : PANEL_W;
      lh        = sideways ? PANEL_W : PANEL_H;
      byte_addr = 0;
      pix_mask  = '0;
      if (x < 0 || x >= lw || y < 0 || y >= lh) begin
         return 1'b0;
      end
      case (shadow_rotation)
         rmfb_pkg::ROT_90: begin
            px = PANEL_W - 1 - y;
            py = x;
         end
         rmfb_pkg::ROT_180: begin
            px = PANEL_W - 1 - x;
            py = PANEL_H - 1 - y;
         end
         rmfb_pkg::ROT_270: begin
            px = y;
            py = PANEL_H - 1 - x;
         end
         default: begin
            px = x;
            py = y;
         end
      endcase
      // Pages of 8 rows, one byte per physical column
      byte_addr = (py / PAGE_ROWS) * PANEL_W + px;
      pix_mask  = BYTE_W'(1) << (py % PAGE_ROWS);
      return 1'b1;
   endfunction

   function automatic void paint_pixel(input int x, input int y, input logic lit);
      int byte_addr;
      logic [BYTE_W-1:0] pix_mask;
      if (locate_pixel(x, y, byte_addr, pix_mask)) begin
         if (lit) begin
            frame_shadow[byte_addr] = frame_shadow[byte_addr] | pix_mask;
         end else begin
            frame_shadow[byte_addr] = frame_shadow[byte_addr] & ~pix_mask;
         end
      end
   endfunction

   // Apply one request to the shadow store and return the pixel value it should answer.
   function automatic logic apply_request(input pixel_request_type cmd);
      int x, y, len, byte_addr;
      logic [BYTE_W-1:0] pix_mask;
      logic pixel;
      x     = int'($signed(cmd.x_coord));
      y     = int'($signed(cmd.y_coord));
      len   = int'(cmd.run_length);
      pixel = 1'b0;
      case (cmd.op)
         rmfb_pkg::OP_SET: paint_pixel(x, y, cmd.ink);
         rmfb_pkg::OP_READ: begin
            if (locate_pixel(x, y, byte_addr, pix_mask)) begin
               pixel = |(frame_shadow[byte_addr] & pix_mask);
            end
         end
         // Runs step at full precision; each pixel clips on its own
         rmfb_pkg::OP_HRUN: begin
            for (int i = 0; i < len; i++) paint_pixel(x + i, y, cmd.ink);
         end
         rmfb_pkg::OP_VRUN: begin
            for (int i = 0; i < len; i++) paint_pixel(x, y + i, cmd.ink);
         end
         rmfb_pkg::OP_FILL: begin
            for (int b = 0; b < STORE_BYTES; b++) begin
               frame_shadow[b] = cmd.ink ? rmfb_pkg::FILL_LIT : '0;
            end
         end
         default: ;
      endcase
      return pixel;
   endfunction

   // Build a random request. A flush request is an on-screen read: it goes through the
   // store behind everything queued, so its response means the engine has gone idle.
   function automatic pixel_request_type pick_request(input bit flush);
      pixel_request_type cmd;
      bit sideways;
      int lw, lh, roll, x, y;
      sideways = (shadow_rotation == rmfb_pkg::ROT_90) ||
                 (shadow_rotation == rmfb_pkg::ROT_270);
      lw       = sideways ? PANEL_H : PANEL_W;
      lh       = sideways ? PANEL_W : PANEL_H;
      roll     = $urandom_range(0, 99);
      cmd      = '0;
      if (flush) begin
         cmd.op = rmfb_pkg::OP_READ;
      end else if (roll < 30) begin
         cmd.op = rmfb_pkg::OP_SET;
      end else if (roll < 62) begin
         cmd.op = rmfb_pkg::OP_READ;
      end else if (roll < 78) begin
         cmd.op = rmfb_pkg::OP_HRUN;
      end else if (roll < 94) begin
         cmd.op = rmfb_pkg::OP_VRUN;
      end else if (roll < 96) begin
         cmd.op = rmfb_pkg::OP_FILL;
      end else begin
         case ($urandom_range(0, 2))
            0:       cmd.op = OP_SPARE5;
            1:       cmd.op = OP_SPARE6;
            default: cmd.op = OP_SPARE7;
         endcase
      end
      // Mostly near the display with a margin to hit the edges; sometimes anywhere
      if (flush) begin
         x = $urandom_range(0, lw - 1);
         y = $urandom_range(0, lh - 1);
         cmd.x_coord = COORD_IN_W'(x);
         cmd.y_coord = COORD_IN_W'(y);
      end else if ($urandom_range(0, 6) == 0) begin
         cmd.x_coord = COORD_IN_W'($urandom);
         cmd.y_coord = COORD_IN_W'($urandom);
      end else begin
         x = int'($urandom_range(0, lw + 7)) - 4;
         y = int'($urandom_range(0, lh + 7)) - 4;
         cmd.x_coord = COORD_IN_W'(x);
         cmd.y_coord = COORD_IN_W'(y);
      end
      roll = $urandom_range(0, 9);
      if (roll < 6) begin
         cmd.run_length = RUN_W'($urandom_range(0, PANEL_W + 8));
      end else if (roll < 9) begin
         cmd.run_length = RUN_W'($urandom_range(0, 15));
      end else begin
         cmd.run_length = RUN_W'($urandom);
      end
      cmd.ink = ($urandom_range(0, 3) != 0);
      return cmd;
   endfunction

   // Present one request, hold it until accepted, then maybe idle the channel for a burst.
   task automatic issue_request(input pixel_request_type cmd);
      int gap;
      logic pixel;
      req_valid      <= 1'b1;
      req_op         <= cmd.op;
      req_x_coord    <= cmd.x_coord;
      req_y_coord    <= cmd.y_coord;
      req_run_length <= cmd.run_length;
      req_ink        <= cmd.ink;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // Accepted: advance the shadow store and queue the owed pixel value
      pixel = apply_request(cmd);
      pending_pixels.push_back(cmd.typed ? cmd.typed_pixel : pixel);
      if (!quiet_run && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Write the rotation register once every owed response has come back.
   task automatic write_rotation(input logic [ROT_W-1:0] rot);
      while (pending_pixels.size() != 0) @(posedge clock);
      csr_valid    <= 1'b1;
      csr_rotation <= rot;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid       <= 1'b0;
      shadow_rotation  = rot;
   endtask

   // Response side: accept with random stall bursts, none in the quiet phase.
   always @(posedge clock) begin
      if (reset || quiet_run) begin
         rsp_ready <= 1'b1;
      end else if (ready_hold > 0) begin
         rsp_ready  <= 1'b0;
         ready_hold <= ready_hold - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_ready  <= 1'b0;
         ready_hold <= $urandom_range(0, 5);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Check every accepted response against the oldest owed value; watch for a hang.
   always @(posedge clock) begin : check_responses
      logic want;
      if (reset) begin
         stuck_cycles <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_pixels.size() == 0) begin
               $error("pixel_value: expected no response, actual %0b", rsp_pixel_value);
               mismatch_count++;
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_pixel_value !== want) begin
                  $error("pixel_value: expected %0b, actual %0b", want, rsp_pixel_value);
                  mismatch_count++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            stuck_cycles <= 0;
         end else if (stuck_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end else begin
            stuck_cycles <= stuck_cycles + 1;
         end
      end
   end

   initial begin : stimulus
      pixel_request_type cmd;
      int counted;

      // Directed rows at rotation 0 right after reset. Fields: op, x, y, length, ink,
      // typed, typed pixel. Rows with typed low are checked against the shadow store.
      directed_table = '{
         // cleared store reads dark
         '{rmfb_pkg::OP_READ, 16'd0,       16'd0,       12'd0,    1'b0, 1'b1, 1'b0},
         // opposite corners light up
         '{rmfb_pkg::OP_SET,  16'd0,       16'd0,       12'd0,    1'b1, 1'b1, 1'b0},
         '{rmfb_pkg::OP_READ, 16'd0,       16'd0,       12'd0,    1'b0, 1'b1, 1'b1},
         '{rmfb_pkg::OP_SET,  16'd127,     16'd63,      12'd0,    1'b1, 1'b1, 1'b0},
         '{rmfb_pkg::OP_READ, 16'd127,     16'd63,      12'd4095, 1'b1, 1'b1, 1'b1},
         // off the display on each side: reads give 0, writes do nothing
         '{rmfb_pkg::OP_READ, 16'd128,     16'd0,       12'd0,    1'b0, 1'b1, 1'b0},
         '{rmfb_pkg::OP_READ, 16'(-1),     16'd63,      12'd0,    1'b0, 1'b1, 1'b0},
         '{rmfb_pkg::OP_SET,  16'(-32768), 16'd32767,   12'd0,    1'b1, 1'b1, 1'b0},
         '{rmfb_pkg::OP_READ, 16'd32767,   16'(-32768), 12'd0,    1'b0, 1'b1, 1'b0},
         // long run starting far left: only its on-screen tail is drawn
         '{rmfb_pkg::OP_HRUN, 16'(-4000),  16'd5,       12'd4095, 1'b1, 1'b1, 1'b0},
         '{rmfb_pkg::OP_READ, 16'd95,      16'd5,       12'd0,    1'b0, 1'b0, 1'b0},
         '{rmfb_pkg::OP_READ, 16'd96,      16'd5,       12'd0,    1'b0, 1'b0, 1'b0},
         // run near the top of the coordinate range must not wrap around
         '{rmfb_pkg::OP_HRUN, 16'd32700,   16'd1,       12'd4095, 1'b1, 1'b1, 1'b0},
         '{rmfb_pkg::OP_READ, 16'd0,       16'd1,       12'd0,    1'b0, 1'b0, 1'b0},
         // vertical run crossing the top edge
         '{rmfb_pkg::OP_VRUN, 16'd10,      16'(-3),     12'd10,   1'b1, 1'b1, 1'b0},
         '{rmfb_pkg::OP_READ, 16'd10,      16'd6,       12'd0,    1'b0, 1'b0, 1'b0},
         // zero-length run draws nothing
         '{rmfb_pkg::OP_VRUN, 16'd20,      16'd0,       12'd0,    1'b1, 1'b1, 1'b0},
         '{rmfb_pkg::OP_READ, 16'd20,      16'd0,       12'd0,    1'b0, 1'b0, 1'b0},
         // erase a pixel
         '{rmfb_pkg::OP_SET,  16'd0,       16'd0,       12'd0,    1'b0, 1'b1, 1'b0},
         '{rmfb_pkg::OP_READ, 16'd0,       16'd0,       12'd0,    1'b0, 1'b1, 1'b0},
         // unused op codes change nothing and answer 0
         '{OP_SPARE5,         16'd1,       16'd1,       12'd4095, 1'b1, 1'b1, 1'b0},
         '{OP_SPARE6,         16'd2,       16'd2,       12'd8,    1'b1, 1'b1, 1'b0},
         '{OP_SPARE7,         16'hFFFF,    16'hFFFF,    12'hFFF,  1'b1, 1'b1, 1'b0},
         // fill lit, then dark
         '{rmfb_pkg::OP_FILL, 16'hFFFF,    16'hFFFF,    12'hFFF,  1'b1, 1'b1, 1'b0},
         '{rmfb_pkg::OP_READ, 16'd64,      16'd32,      12'd0,    1'b0, 1'b1, 1'b1},
         '{rmfb_pkg::OP_FILL, 16'd0,       16'd0,       12'd0,    1'b0, 1'b1, 1'b0},
         '{rmfb_pkg::OP_READ, 16'd64,      16'd32,      12'd0,    1'b0, 1'b1, 1'b0}
      };
      // Visit every rotation, both extremes more than once, and end back at 0
      rotation_plan = '{rmfb_pkg::ROT_90, rmfb_pkg::ROT_270, rmfb_pkg::ROT_180,
                        rmfb_pkg::ROT_0, rmfb_pkg::ROT_270, rmfb_pkg::ROT_180,
                        rmfb_pkg::ROT_90, rmfb_pkg::ROT_0};

      // Drive every input to a known value before the first edge
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_op         <= rmfb_pkg::OP_SET;
      req_x_coord    <= '0;
      req_y_coord    <= '0;
      req_run_length <= '0;
      req_ink        <= 1'b0;
      csr_valid      <= 1'b0;
      csr_rotation   <= rmfb_pkg::ROT_0;
      for (int b = 0; b < STORE_BYTES; b++) frame_shadow[b] = '0;
      shadow_rotation = rmfb_pkg::ROT_0;

      // Hold reset, then release it; the clearing pass after it keeps req_ready low
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) issue_request(directed_table[i]);

      // Random phases, one rotation each; the last phase runs without idling.
      // Each phase closes with an on-screen read so the engine is idle before the
      // next rotation write.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         req_valid <= 1'b0;
         write_rotation(rotation_plan[p]);
         if (p == PHASE_COUNT - 1) begin
            quiet_run = 1'b1;
         end
         counted = 0;
         while (counted < RANDOM_PER_PHASE) begin
            cmd = pick_request(1'b0);
            issue_request(cmd);
            if (cmd.op <= rmfb_pkg::OP_FILL) begin
               counted++;
            end
         end
         issue_request(pick_request(1'b1));
      end
      req_valid <= 1'b0;

      // Drain owed responses, then watch a little longer for strays
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
